@@ rtl/core/tedist_pkg.sv @@
// ----------------------------------------------------------------------------
// tedist_pkg
// Shared types and constants for the transposition edit distance block:
// command codes, transfer payload structs and field widths.
// ----------------------------------------------------------------------------
package tedist_pkg;

    localparam int DEF_MAX_LEN = 32;
    localparam int CMD_W       = 2;
    localparam int SYM_W       = 8;
    localparam int DIST_W      = 6;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_FIRST  = 2'd0,
        CMD_LOAD_SECOND = 2'd1,
        CMD_COMPUTE     = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SYM_W-1:0] symbol;
    } item_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } result_t;

endpackage

@@ rtl/core/transposition_edit_distance.sv @@
// ----------------------------------------------------------------------------
// transposition_edit_distance
// Optimal string alignment distance between two loaded byte strings.
//
// Usage: items arrive on the item channel (valid/ready). cmd LOAD_FIRST or
// LOAD_SECOND appends symbol to the first or second word; symbols past
// MAX_LEN are dropped and reported in the overflow bit. COMPUTE walks the
// table and sends one transfer on the result channel, then clears both
// words and the overflow flag. Other commands are ignored.
// Load items are accepted back to back while idle. For two nonempty
// words, a compute first writes the initial row of the table, then for
// each row fetches the first-word symbol and for each cell reads the row
// RAMs and then updates the cell in the shared min/compare unit. With an
// empty word the result is valid in the cycle after the compute is taken.
// The block takes no item while computing or while the result waits.
// A stalled receiver holds the result register; nothing is lost.
// Reset empties both words and clears the flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module transposition_edit_distance
    import tedist_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int DW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = DW + 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INIT = 6'b000010,
        S_ROW  = 6'b000100,
        S_RD   = 6'b001000,
        S_CALC = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    logic [DW-1:0]  first_len_reg, first_len_next;
    logic [DW-1:0]  second_len_reg, second_len_next;
    logic           dropped_reg, dropped_next;
    logic [DW-1:0]  i_reg, i_next;
    logic [DW-1:0]  j_reg, j_next;
    logic [1:0]     cur_sel_reg, cur_sel_next;
    logic [DW-1:0]  left_reg, left_next;
    logic [DW-1:0]  diag_reg, diag_next;
    logic [SYM_W-1:0] a_prev_reg, a_prev_next;
    logic [SYM_W-1:0] b_prev_reg, b_prev_next;
    result_t        result_reg, result_next;

    logic             accept;
    logic             first_we, second_we;
    logic [SYM_W-1:0] first_rdata, second_rdata;
    logic [DW-1:0]    i_minus1, j_minus1;
    logic [1:0]       prev_sel, rbp_sel;
    logic             row_wr_en;
    logic [DW-1:0]    row_waddr, row_wdata;
    logic [DW-1:0]    row_raddr [3];
    logic [DW-1:0]    row_rdata [3];
    logic [DW-1:0]    prev_rdata, rbp_rdata;
    logic [CW-1:0]    cand_up, cand_left, cand_diag, cand_swap, best_w;
    logic [DW-1:0]    best;
    logic             swap_ok;

    function automatic logic [DIST_W-1:0] sat_dist(input logic [DW-1:0] v);
        logic [DW+DIST_W-1:0] w;
        w = {{DIST_W{1'b0}}, v};
        if (w > (DW+DIST_W)'(DIST_MAX))
        begin
            return DIST_MAX;
        end
        return w[DIST_W-1:0];
    endfunction

    assign accept       = item_valid && item_ready;
    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = (state_reg == S_OUT);
    assign result       = result_reg;

    assign i_minus1 = i_reg - DW'(1);
    assign j_minus1 = j_reg - DW'(1);

    assign first_we  = accept && (item.cmd == CMD_LOAD_FIRST) &&
                       (first_len_reg < DW'(MAX_LEN));
    assign second_we = accept && (item.cmd == CMD_LOAD_SECOND) &&
                       (second_len_reg < DW'(MAX_LEN));

    tedist_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_LEN)
    ) u_first_ram (
        .clk   (clk),
        .we    (first_we),
        .waddr (first_len_reg[AW-1:0]),
        .wdata (item.symbol),
        .raddr (i_minus1[AW-1:0]),
        .rdata (first_rdata)
    );

    tedist_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_LEN)
    ) u_second_ram (
        .clk   (clk),
        .we    (second_we),
        .waddr (second_len_reg[AW-1:0]),
        .wdata (item.symbol),
        .raddr (j_minus1[AW-1:0]),
        .rdata (second_rdata)
    );

    assign prev_sel = (cur_sel_reg == 2'd0) ? 2'd2 : cur_sel_reg - 2'd1;
    assign rbp_sel  = (cur_sel_reg == 2'd2) ? 2'd0 : cur_sel_reg + 2'd1;

    assign row_wr_en = (state_reg == S_INIT) || (state_reg == S_ROW) ||
                       (state_reg == S_CALC);
    assign row_waddr = (state_reg == S_ROW) ? '0 : j_reg;

    always_comb
    begin
        case (state_reg)
            S_INIT:  row_wdata = j_reg;
            S_ROW:   row_wdata = i_reg;
            default: row_wdata = best;
        endcase
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_row
        assign row_raddr[k] = (prev_sel == 2'(k)) ? j_reg :
                              (j_reg < DW'(2)) ? '0 : j_reg - DW'(2);

        tedist_ram #(
            .WIDTH (DW),
            .DEPTH (MAX_LEN + 1)
        ) u_row_ram (
            .clk   (clk),
            .we    (row_wr_en && (cur_sel_reg == 2'(k))),
            .waddr (row_waddr),
            .wdata (row_wdata),
            .raddr (row_raddr[k]),
            .rdata (row_rdata[k])
        );
    end

    always_comb
    begin
        case (prev_sel)
            2'd0:    prev_rdata = row_rdata[0];
            2'd1:    prev_rdata = row_rdata[1];
            default: prev_rdata = row_rdata[2];
        endcase
        case (rbp_sel)
            2'd0:    rbp_rdata = row_rdata[0];
            2'd1:    rbp_rdata = row_rdata[1];
            default: rbp_rdata = row_rdata[2];
        endcase
    end

    // shared cell unit: min of delete, insert, substitute and swap
    assign swap_ok   = (i_reg > DW'(1)) && (j_reg > DW'(1)) &&
                       (first_rdata == b_prev_reg) && (a_prev_reg == second_rdata);
    assign cand_up   = CW'(prev_rdata) + CW'(1);
    assign cand_left = CW'(left_reg) + CW'(1);
    assign cand_diag = CW'(diag_reg) + CW'(first_rdata != second_rdata);
    assign cand_swap = CW'(rbp_rdata) + CW'(1);

    always_comb
    begin
        best_w = (cand_up < cand_left) ? cand_up : cand_left;
        if (cand_diag < best_w)
        begin
            best_w = cand_diag;
        end
        if (swap_ok && (cand_swap < best_w))
        begin
            best_w = cand_swap;
        end
    end

    assign best = best_w[DW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        dropped_next    = dropped_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        cur_sel_next    = cur_sel_reg;
        left_next       = left_reg;
        diag_next       = diag_reg;
        a_prev_next     = a_prev_reg;
        b_prev_next     = b_prev_reg;
        result_next     = result_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.cmd)
                        CMD_LOAD_FIRST:
                        begin
                            if (first_we)
                            begin
                                first_len_next = first_len_reg + DW'(1);
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        CMD_LOAD_SECOND:
                        begin
                            if (second_we)
                            begin
                                second_len_next = second_len_reg + DW'(1);
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        CMD_COMPUTE:
                        begin
                            if ((first_len_reg == '0) || (second_len_reg == '0))
                            begin
                                result_next.distance = sat_dist(
                                    (first_len_reg == '0) ? second_len_reg
                                                          : first_len_reg);
                                result_next.overflow = dropped_reg;
                                first_len_next  = '0;
                                second_len_next = '0;
                                dropped_next    = 1'b0;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                j_next       = '0;
                                i_next       = '0;
                                cur_sel_next = 2'd0;
                                state_next   = S_INIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                if (j_reg == second_len_reg)
                begin
                    i_next       = DW'(1);
                    cur_sel_next = 2'd1;
                    state_next   = S_ROW;
                end
                else
                begin
                    j_next = j_reg + DW'(1);
                end
            end
            S_ROW:
            begin
                a_prev_next = first_rdata;
                left_next   = i_reg;
                diag_next   = i_minus1;
                j_next      = DW'(1);
                state_next  = S_RD;
            end
            S_RD:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                left_next   = best;
                diag_next   = prev_rdata;
                b_prev_next = second_rdata;
                if (j_reg == second_len_reg)
                begin
                    if (i_reg == first_len_reg)
                    begin
                        result_next.distance = sat_dist(best);
                        result_next.overflow = dropped_reg;
                        first_len_next  = '0;
                        second_len_next = '0;
                        dropped_next    = 1'b0;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        i_next       = i_reg + DW'(1);
                        cur_sel_next = rbp_sel;
                        state_next   = S_ROW;
                    end
                end
                else
                begin
                    j_next     = j_reg + DW'(1);
                    state_next = S_RD;
                end
            end
            S_OUT:
            begin
                if (result_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            dropped_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            dropped_reg    <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        cur_sel_reg <= cur_sel_next;
        left_reg    <= left_next;
        diag_reg    <= diag_next;
        a_prev_reg  <= a_prev_next;
        b_prev_reg  <= b_prev_next;
        result_reg  <= result_next;
    end

`ifndef ASSERT_OFF
    a_ready_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> !result_valid)
        else $error("item_ready while result pending");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (first_len_reg <= DW'(MAX_LEN)) && (second_len_reg <= DW'(MAX_LEN)))
        else $error("word length beyond MAX_LEN");

    a_calc_column: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC) |-> (j_reg != '0) && (j_reg <= second_len_reg))
        else $error("cell column out of range");

    a_calc_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC) |-> (i_reg != '0) && (i_reg <= first_len_reg))
        else $error("cell row out of range");

    a_compute_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.cmd == CMD_COMPUTE) && (first_len_reg != '0) &&
        (second_len_reg != '0) |=> (state_reg == S_INIT))
        else $error("compute did not start table walk");
`endif

endmodule

@@ rtl/core/tedist_ram.sv @@
// ----------------------------------------------------------------------------
// tedist_ram
// Generic simple dual port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tedist_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ tb/transposition_edit_distance_tb.sv @@
// ----------------------------------------------------------------------------
// transposition_edit_distance_tb
// Loads word pairs into the edit distance block and checks every result
// against a local optimal string alignment predictor. Covers empty words,
// byte extremes, adjacent swaps, full words, dropped symbols and the unused
// command, then random word pairs with random idling on both channels.
// ----------------------------------------------------------------------------
module transposition_edit_distance_tb;
    import tedist_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_CAP = DEF_MAX_LEN;
    localparam int ITEM_GOAL = 1900;
    localparam int IDLE_LIMIT = 25000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX = 10;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    result_t result;

    item_t pending_items[$];
    result_t expected_results[$];

    logic [SYM_W-1:0] first_syms[WORD_CAP];
    logic [SYM_W-1:0] second_syms[WORD_CAP];
    int first_len = 0;
    int second_len = 0;
    logic dropped = 1'b0;

    int item_total = 0;
    int failures = 0;
    int idle_cycles = 0;
    int tx_hold = 0;
    int rx_hold = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    transposition_edit_distance #(
        .MAX_LEN(WORD_CAP)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [DIST_W-1:0] osa_distance();
        int older[WORD_CAP+1];
        int prev[WORD_CAP+1];
        int cur[WORD_CAP+1];
        int i;
        int j;
        int cost;
        int best;
        for (j = 0; j <= second_len; j++)
        begin
            cur[j] = j;
            prev[j] = j;
            older[j] = j;
        end
        for (i = 1; i <= first_len; i++)
        begin
            older = prev;
            prev = cur;
            cur[0] = i;
            for (j = 1; j <= second_len; j++)
            begin
                cost = (first_syms[i-1] == second_syms[j-1]) ? 0 : 1;
                best = (prev[j] + 1 < cur[j-1] + 1) ? prev[j] + 1 : cur[j-1] + 1;
                if (prev[j-1] + cost < best)
                    best = prev[j-1] + cost;
                if (i > 1 && j > 1 && first_syms[i-1] == second_syms[j-2]
                        && first_syms[i-2] == second_syms[j-1]
                        && older[j-2] + 1 < best)
                    best = older[j-2] + 1;
                cur[j] = best;
            end
        end
        if (cur[second_len] > int'(DIST_MAX))
            return DIST_MAX;
        return cur[second_len][DIST_W-1:0];
    endfunction

    task automatic apply_item(input item_t it);
        result_t want;
        case (it.cmd)
            CMD_LOAD_FIRST:
            begin
                if (first_len < WORD_CAP)
                begin
                    first_syms[first_len] = it.symbol;
                    first_len++;
                end
                else
                    dropped = 1'b1;
            end
            CMD_LOAD_SECOND:
            begin
                if (second_len < WORD_CAP)
                begin
                    second_syms[second_len] = it.symbol;
                    second_len++;
                end
                else
                    dropped = 1'b1;
            end
            CMD_COMPUTE:
            begin
                want.distance = osa_distance();
                want.overflow = dropped;
                expected_results.push_back(want);
                first_len = 0;
                second_len = 0;
                dropped = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym);
        item_t it;
        it.cmd = cmd;
        it.symbol = sym;
        pending_items.push_back(it);
        if (cmd != CMD_UNUSED)
            item_total++;
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 6);
        if (r < 90)
            return $urandom_range(7, 16);
        if (r < 96)
            return $urandom_range(17, WORD_CAP);
        return $urandom_range(WORD_CAP + 1, WORD_CAP + 3);
    endfunction

    function automatic logic [SYM_W-1:0] make_sym(input int mode, input int base);
        if (mode == 0)
            return SYM_W'($urandom_range(0, 255));
        if (mode == 1)
            return SYM_W'(base + int'($urandom_range(0, 2)));
        return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endfunction

    // negative lengths pick at random; a random second word is mostly an edit of the first
    task automatic add_pair(input int n_req, input int m_req);
        logic [SYM_W-1:0] a[$];
        logic [SYM_W-1:0] b[$];
        logic [SYM_W-1:0] t;
        int n;
        int m;
        int mode;
        int base;
        int pos;
        int i;
        int j;
        n = (n_req < 0) ? pick_len() : n_req;
        mode = $urandom_range(0, 2);
        base = $urandom_range(0, 253);
        for (i = 0; i < n; i++)
            a.push_back(make_sym(mode, base));
        if (m_req < 0 && $urandom_range(0, 9) < 6)
        begin
            b = a;
            repeat ($urandom_range(0, 3))
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        if (b.size() >= 2)
                        begin
                            pos = $urandom_range(0, b.size() - 2);
                            t = b[pos];
                            b[pos] = b[pos+1];
                            b[pos+1] = t;
                        end
                    end
                    1:
                    begin
                        if (b.size() > 0)
                            b[$urandom_range(0, b.size() - 1)] = make_sym(mode, base);
                    end
                    2: b.insert($urandom_range(0, b.size()), make_sym(mode, base));
                    default:
                    begin
                        if (b.size() > 0)
                            b.delete($urandom_range(0, b.size() - 1));
                    end
                endcase
            end
        end
        else
        begin
            m = (m_req < 0) ? pick_len() : m_req;
            for (j = 0; j < m; j++)
                b.push_back(make_sym(mode, base));
        end
        i = 0;
        j = 0;
        while (i < a.size() || j < b.size())
        begin
            if (j >= b.size() || (i < a.size() && $urandom_range(0, 1)))
            begin
                push_item(CMD_LOAD_FIRST, a[i]);
                i++;
            end
            else
            begin
                push_item(CMD_LOAD_SECOND, b[j]);
                j++;
            end
            if ($urandom_range(0, 49) == 0)
                push_item(CMD_UNUSED, SYM_W'($urandom_range(0, 255)));
        end
        push_item(CMD_COMPUTE, SYM_W'($urandom_range(0, 255)));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            tx_hold <= 0;
        end
        else
        begin
            if (item_valid && item_ready)
                apply_item(item);
            if (!item_valid || item_ready)
            begin
                if (tx_hold > 0)
                begin
                    item_valid <= 1'b0;
                    tx_hold <= tx_hold - 1;
                end
                else if (pending_items.size() > 0)
                begin
                    item <= pending_items.pop_front();
                    item_valid <= 1'b1;
                    tx_hold <= pick_gap(tx_calm);
                    if ($urandom_range(0, 39) == 0)
                        tx_calm <= !tx_calm;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        int gap;
        result_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            rx_hold <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (failures < REPORT_MAX)
                        $display("unexpected transfer: distance=%0d overflow=%0b",
                                 result.distance, result.overflow);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.distance !== want.distance || result.overflow !== want.overflow)
                    begin
                        if (failures < REPORT_MAX)
                            $display("mismatch: distance exp %0d got %0d, overflow exp %0b got %0b",
                                     want.distance, result.distance, want.overflow,
                                     result.overflow);
                        failures++;
                    end
                end
            end
            gap = rx_hold;
            if (gap == 0 && ((result_valid && result_ready) || $urandom_range(0, 15) == 0))
            begin
                gap = pick_gap(rx_calm);
                if ($urandom_range(0, 29) == 0)
                    rx_calm <= !rx_calm;
            end
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                rx_hold <= gap - 1;
            end
            else
            begin
                result_ready <= 1'b1;
                rx_hold <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        // both words empty, then the unused command with every bit high
        push_item(CMD_COMPUTE, 8'h00);
        push_item(CMD_UNUSED, 8'hFF);
        push_item(CMD_COMPUTE, 8'hFF);
        // empty second word gives the first word's length
        push_item(CMD_LOAD_FIRST, 8'h00);
        push_item(CMD_LOAD_FIRST, 8'hFF);
        push_item(CMD_COMPUTE, 8'h00);
        push_item(CMD_LOAD_SECOND, 8'hFF);
        push_item(CMD_COMPUTE, 8'h00);
        // adjacent swap
        push_item(CMD_LOAD_FIRST, 8'h5A);
        push_item(CMD_LOAD_FIRST, 8'hA5);
        push_item(CMD_LOAD_SECOND, 8'hA5);
        push_item(CMD_LOAD_SECOND, 8'h5A);
        push_item(CMD_COMPUTE, 8'h00);
        // equal words
        push_item(CMD_LOAD_FIRST, 8'h61);
        push_item(CMD_LOAD_SECOND, 8'h61);
        push_item(CMD_LOAD_FIRST, 8'h62);
        push_item(CMD_LOAD_SECOND, 8'h62);
        push_item(CMD_LOAD_FIRST, 8'h63);
        push_item(CMD_LOAD_SECOND, 8'h63);
        push_item(CMD_COMPUTE, 8'h00);
        // full words, dropped symbols on each side
        add_pair(WORD_CAP + 1, 2);
        add_pair(3, WORD_CAP + 2);
        add_pair(WORD_CAP, WORD_CAP);
        while (item_total < ITEM_GOAL)
            add_pair(-1, -1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $display("%0d results never arrived", expected_results.size());
            failures++;
        end
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
